@@ design/nbel_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nbel_pkg
// Shared widths, register indexes, controller states and the command and
// status groups between the region lookup controller and its datapath.
// ----------------------------------------------------------------------------
package nbel_pkg;

  localparam int COORD_W     = 32;
  localparam int LEN_W       = 31;
  localparam int TRIG_W      = 16;
  localparam int COUNT_W     = 5;
  localparam int ENTRY_W     = 4;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int PROD_W      = DIFF_W + TRIG_W;
  localparam int ACC_W       = PROD_W + 1;
  localparam int HALF_SHIFT  = 14;

  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Z     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COS_ANGLE    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SIN_ANGLE    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_REGION_COUNT = 3'd5;

  localparam logic signed [TRIG_W-1:0] COS_RESET = 16'sd32767;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_DXC,
    ST_MUL_DYS,
    ST_MUL_DYC,
    ST_MUL_DXS,
    ST_ACC_V,
    ST_ABS,
    ST_SCAN,
    ST_FINISH
  } nbel_state_t;

  typedef enum logic [1:0] {
    MUL_DX_COS,
    MUL_DY_SIN,
    MUL_DY_COS,
    MUL_DX_SIN
  } nbel_mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_U_SET,
    ACC_U_ADD,
    ACC_V_SET,
    ACC_V_SUB
  } nbel_acc_op_t;

  typedef struct packed {
    logic [LEN_W-1:0] len_x;
    logic [LEN_W-1:0] len_y;
    logic [LEN_W-1:0] len_z;
    logic [LEN_W-1:0] edge_h;
    logic [LEN_W-1:0] edge_v;
  } nbel_entry_t;

  typedef struct packed {
    logic          load_point;
    logic          write_entry;
    logic          mul_en;
    nbel_mul_sel_t mul_sel;
    nbel_acc_op_t  acc_op;
    logic          scan_start;
    logic          scan_eval;
    logic          scan_next;
    logic          result_load;
  } nbel_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic hit;
    logic last;
    logic out_free;
  } nbel_status_t;

endpackage
`default_nettype wire

@@ design/nbel_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nbel_ctrl
// Sequencer for one query: four shared multiplies, magnitude step, entry
// scan and result hand-off. Load items are taken in idle.
// ----------------------------------------------------------------------------
module nbel_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_mode,
  output logic                     in_ready,
  input  wire nbel_pkg::nbel_status_t status,
  output nbel_pkg::nbel_cmd_t      cmd
);
  import nbel_pkg::*;

  nbel_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && !in_mode) state_nxt = ST_MUL_DXC;
      end
      ST_MUL_DXC: state_nxt = ST_MUL_DYS;
      ST_MUL_DYS: state_nxt = ST_MUL_DYC;
      ST_MUL_DYC: state_nxt = ST_MUL_DXS;
      ST_MUL_DXS: state_nxt = ST_ACC_V;
      ST_ACC_V:   state_nxt = ST_ABS;
      ST_ABS: begin
        state_nxt = status.count_zero ? ST_FINISH : ST_SCAN;
      end
      ST_SCAN: begin
        if (status.hit || status.last) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    cmd.mul_sel = MUL_DX_COS;
    cmd.acc_op  = ACC_HOLD;
    unique case (state_r)
      ST_IDLE: begin
        in_ready        = 1'b1;
        cmd.load_point  = in_valid && !in_mode;
        cmd.write_entry = in_valid && in_mode;
      end
      ST_MUL_DXC: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DX_COS;
      end
      ST_MUL_DYS: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DY_SIN;
        cmd.acc_op  = ACC_U_SET;
      end
      ST_MUL_DYC: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DY_COS;
        cmd.acc_op  = ACC_U_ADD;
      end
      ST_MUL_DXS: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DX_SIN;
        cmd.acc_op  = ACC_V_SET;
      end
      ST_ACC_V: begin
        cmd.acc_op = ACC_V_SUB;
      end
      ST_ABS: begin
        cmd.scan_start = 1'b1;
      end
      ST_SCAN: begin
        cmd.scan_eval = 1'b1;
        cmd.scan_next = !(status.hit || status.last);
      end
      ST_FINISH: begin
        cmd.result_load = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ design/nbel_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nbel_datapath
// Configuration registers, entry table, offset and rotation arithmetic on
// one shared multiplier, per-entry containment compare and result register.
// ----------------------------------------------------------------------------
module nbel_datapath #(
  parameter int MAX_REGIONS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_we,
  input  wire logic        [nbel_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic        [nbel_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic signed [nbel_pkg::COORD_W-1:0]   in_point_x,
  input  wire logic signed [nbel_pkg::COORD_W-1:0]   in_point_y,
  input  wire logic signed [nbel_pkg::COORD_W-1:0]   in_point_z,
  input  wire logic        [nbel_pkg::ENTRY_W-1:0]   in_entry_index,
  input  wire logic        [nbel_pkg::LEN_W-1:0]     in_side_x,
  input  wire logic        [nbel_pkg::LEN_W-1:0]     in_side_y,
  input  wire logic        [nbel_pkg::LEN_W-1:0]     in_side_z,
  input  wire logic        [nbel_pkg::LEN_W-1:0]     in_edge_horizontal_in,
  input  wire logic        [nbel_pkg::LEN_W-1:0]     in_edge_vertical_in,
  input  wire nbel_pkg::nbel_cmd_t                   cmd,
  output nbel_pkg::nbel_status_t                     status,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic             [nbel_pkg::LEN_W-1:0]     out_edge_horizontal,
  output logic             [nbel_pkg::LEN_W-1:0]     out_edge_vertical,
  output logic                                       out_found,
  output logic             [nbel_pkg::ENTRY_W-1:0]   out_region_index
);
  import nbel_pkg::*;

  localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CW = (IW + 1 > COUNT_W) ? IW + 1 : COUNT_W;
  localparam int AW = ((IW > ENTRY_W) ? IW : ENTRY_W) + 1;

  logic signed [COORD_W-1:0] center_x_r, center_y_r, center_z_r;
  logic signed [TRIG_W-1:0]  cos_r, sin_r;
  logic        [COUNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      center_z_r <= '0;
      cos_r      <= COS_RESET;
      sin_r      <= '0;
      count_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTER_X:     center_x_r <= cfg_data[COORD_W-1:0];
        REG_CENTER_Y:     center_y_r <= cfg_data[COORD_W-1:0];
        REG_CENTER_Z:     center_z_r <= cfg_data[COORD_W-1:0];
        REG_COS_ANGLE:    cos_r      <= cfg_data[TRIG_W-1:0];
        REG_SIN_ANGLE:    sin_r      <= cfg_data[TRIG_W-1:0];
        REG_REGION_COUNT: count_r    <= cfg_data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // offsets from the shared center
  logic signed [DIFF_W-1:0] dx_r, dy_r, dz_r;

  always_ff @(posedge clk) begin
    if (cmd.load_point) begin
      dx_r <= DIFF_W'(in_point_x) - DIFF_W'(center_x_r);
      dy_r <= DIFF_W'(in_point_y) - DIFF_W'(center_y_r);
      dz_r <= DIFF_W'(in_point_z) - DIFF_W'(center_z_r);
    end
  end

  // rotation on one multiplier
  logic signed [DIFF_W-1:0] mul_a;
  logic signed [TRIG_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  u_r, v_r;

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_DX_COS: begin mul_a = dx_r; mul_b = cos_r; end
      MUL_DY_SIN: begin mul_a = dy_r; mul_b = sin_r; end
      MUL_DY_COS: begin mul_a = dy_r; mul_b = cos_r; end
      MUL_DX_SIN: begin mul_a = dx_r; mul_b = sin_r; end
      default:    begin mul_a = dx_r; mul_b = cos_r; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= PROD_W'(mul_a * mul_b);
    end
    unique case (cmd.acc_op)
      ACC_HOLD:  begin end
      ACC_U_SET: u_r <= ACC_W'(prod_r);
      ACC_U_ADD: u_r <= u_r + ACC_W'(prod_r);
      ACC_V_SET: v_r <= ACC_W'(prod_r);
      ACC_V_SUB: v_r <= v_r - ACC_W'(prod_r);
      default:   begin end
    endcase
  end

  // magnitudes
  logic [ACC_W-1:0]  abs_u_r, abs_v_r;
  logic [DIFF_W-1:0] abs_z_r;

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      abs_u_r <= u_r[ACC_W-1]   ? ACC_W'(-u_r)   : ACC_W'(u_r);
      abs_v_r <= v_r[ACC_W-1]   ? ACC_W'(-v_r)   : ACC_W'(v_r);
      abs_z_r <= dz_r[DIFF_W-1] ? DIFF_W'(-dz_r) : DIFF_W'(dz_r);
    end
  end

  // entry table
  nbel_entry_t       mem [MAX_REGIONS];
  nbel_entry_t       rdata_r;
  nbel_entry_t       wdata;
  logic [AW-1:0]     wr_index;
  logic              wr_en;
  logic [IW-1:0]     idx_r;
  logic [IW:0]       idx_inc;
  logic [IW-1:0]     rd_addr;

  assign wr_index = AW'(in_entry_index);
  assign wr_en    = cmd.write_entry && (wr_index < AW'(MAX_REGIONS));
  assign wdata    = '{len_x: in_side_x, len_y: in_side_y, len_z: in_side_z,
                      edge_h: in_edge_horizontal_in, edge_v: in_edge_vertical_in};
  assign idx_inc  = {1'b0, idx_r} + (IW + 1)'(1);
  assign rd_addr  = cmd.scan_start ? '0 : idx_inc[IW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_index[IW-1:0]] <= wdata;
    end
    if (cmd.scan_start || cmd.scan_next) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // scan position and containment
  logic [CW-1:0] count_eff;
  logic          hit_c;
  logic          hit_r;

  assign count_eff = (CW'(count_r) > CW'(MAX_REGIONS)) ? CW'(MAX_REGIONS) : CW'(count_r);

  assign hit_c = (abs_u_r <= {5'b0, rdata_r.len_x, {HALF_SHIFT{1'b0}}})
              && (abs_v_r <= {5'b0, rdata_r.len_y, {HALF_SHIFT{1'b0}}})
              && ({abs_z_r, 1'b0} <= {3'b0, rdata_r.len_z});

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      idx_r <= '0;
      hit_r <= 1'b0;
    end else begin
      if (cmd.scan_next) idx_r <= idx_inc[IW-1:0];
      if (cmd.scan_eval) hit_r <= hit_c;
    end
  end

  // result register
  logic                     out_valid_r;
  logic [LEN_W-1:0]         out_eh_r, out_ev_r;
  logic                     out_found_r;
  logic [ENTRY_W-1:0]       out_idx_r;
  logic [IW+ENTRY_W-1:0]    idx_wide;

  assign idx_wide = {{ENTRY_W{1'b0}}, idx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.result_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      out_eh_r    <= hit_r ? rdata_r.edge_h : '1;
      out_ev_r    <= hit_r ? rdata_r.edge_v : '1;
      out_found_r <= hit_r;
      out_idx_r   <= hit_r ? idx_wide[ENTRY_W-1:0] : '0;
    end
  end

  assign status.count_zero = (count_eff == '0);
  assign status.hit        = hit_c;
  assign status.last       = (CW'(idx_inc) >= count_eff);
  assign status.out_free   = !out_valid_r || out_ready;

  assign out_valid           = out_valid_r;
  assign out_edge_horizontal = out_eh_r;
  assign out_edge_vertical   = out_ev_r;
  assign out_found           = out_found_r;
  assign out_region_index    = out_idx_r;

endmodule
`default_nettype wire

@@ design/nested_box_edge_length_lookup.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nested_box_edge_length_lookup
// Point-in-rotated-box lookup returning the edge lengths of the first
// table entry that contains a query point.
// ----------------------------------------------------------------------------
// A load item (mode 1) writes one table entry and is taken in idle
// with no result. A query item (mode 0) keeps the block busy until it
// is done: the offsets are registered at the transfer, successive states
// run the rotation through one shared 33x16 multiplier, a magnitude state
// takes magnitudes and issues the first table read, the scan reads and
// tests one entry per cycle from the table's single read port up to the
// first hit or the last entry in use (none when the count is zero), and a
// finishing state hands the answer to the output register once it is free.
// A waiting result does not block load items. The table needs no clearing after reset.
// ----------------------------------------------------------------------------
module nested_box_edge_length_lookup #(
  parameter int MAX_REGIONS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_we,
  input  wire logic        [nbel_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic        [nbel_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic                                  in_mode,
  input  wire logic signed [nbel_pkg::COORD_W-1:0]   in_point_x,
  input  wire logic signed [nbel_pkg::COORD_W-1:0]   in_point_y,
  input  wire logic signed [nbel_pkg::COORD_W-1:0]   in_point_z,
  input  wire logic        [nbel_pkg::ENTRY_W-1:0]   in_entry_index,
  input  wire logic        [nbel_pkg::LEN_W-1:0]     in_side_x,
  input  wire logic        [nbel_pkg::LEN_W-1:0]     in_side_y,
  input  wire logic        [nbel_pkg::LEN_W-1:0]     in_side_z,
  input  wire logic        [nbel_pkg::LEN_W-1:0]     in_edge_horizontal_in,
  input  wire logic        [nbel_pkg::LEN_W-1:0]     in_edge_vertical_in,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic             [nbel_pkg::LEN_W-1:0]     out_edge_horizontal,
  output logic             [nbel_pkg::LEN_W-1:0]     out_edge_vertical,
  output logic                                       out_found,
  output logic             [nbel_pkg::ENTRY_W-1:0]   out_region_index
);
  import nbel_pkg::*;

  nbel_cmd_t    cmd;
  nbel_status_t status;

  nbel_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  nbel_datapath #(
    .MAX_REGIONS (MAX_REGIONS)
  ) u_datapath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_point_x            (in_point_x),
    .in_point_y            (in_point_y),
    .in_point_z            (in_point_z),
    .in_entry_index        (in_entry_index),
    .in_side_x             (in_side_x),
    .in_side_y             (in_side_y),
    .in_side_z             (in_side_z),
    .in_edge_horizontal_in (in_edge_horizontal_in),
    .in_edge_vertical_in   (in_edge_vertical_in),
    .cmd                   (cmd),
    .status                (status),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_edge_horizontal   (out_edge_horizontal),
    .out_edge_vertical     (out_edge_vertical),
    .out_found             (out_found),
    .out_region_index      (out_region_index)
  );

  a_result_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.result_load |=> out_valid)
    else $error("result load did not raise out_valid");

  a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |->
      ((out_edge_horizontal == '1) && (out_edge_vertical == '1) && (out_region_index == '0)))
    else $error("not-found result carries wrong values");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!cmd.result_load && !cmd.scan_next && !cmd.scan_start))
    else $error("scan or result command while accepting input");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_next |-> !status.last)
    else $error("scan advanced past last entry in use");

endmodule
`default_nettype wire

@@ verif/nbel_tb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbel_tb_pkg
// Item kind codes shared by the region lookup testbench and its checker.
// ----------------------------------------------------------------------------
package nbel_tb_pkg;

  typedef enum logic {
    MODE_QUERY = 1'b0,
    MODE_LOAD  = 1'b1
  } box_mode_t;

endpackage

@@ verif/nested_box_edge_length_lookup_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nested_box_edge_length_lookup_checker
// Watches the register port and both channels of the region lookup, keeps
// its own copy of the registers and the box table, works out the answer of
// every accepted query and compares each result transfer, in order, with it.
// ----------------------------------------------------------------------------
module nested_box_edge_length_lookup_checker #(
  parameter int MAX_REGIONS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic        [nbel_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic        [nbel_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic                                 in_mode,
  input  logic signed [nbel_pkg::COORD_W-1:0]   in_point_x,
  input  logic signed [nbel_pkg::COORD_W-1:0]   in_point_y,
  input  logic signed [nbel_pkg::COORD_W-1:0]   in_point_z,
  input  logic        [nbel_pkg::ENTRY_W-1:0]   in_entry_index,
  input  logic        [nbel_pkg::LEN_W-1:0]     in_side_x,
  input  logic        [nbel_pkg::LEN_W-1:0]     in_side_y,
  input  logic        [nbel_pkg::LEN_W-1:0]     in_side_z,
  input  logic        [nbel_pkg::LEN_W-1:0]     in_edge_horizontal_in,
  input  logic        [nbel_pkg::LEN_W-1:0]     in_edge_vertical_in,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic        [nbel_pkg::LEN_W-1:0]     out_edge_horizontal,
  input  logic        [nbel_pkg::LEN_W-1:0]     out_edge_vertical,
  input  logic                                 out_found,
  input  logic        [nbel_pkg::ENTRY_W-1:0]   out_region_index,
  output int                                   mismatch_count,
  output int                                   results_pending
);
  import nbel_pkg::*;
  import nbel_tb_pkg::*;

  typedef struct packed {
    logic [LEN_W-1:0]   edge_h;
    logic [LEN_W-1:0]   edge_v;
    logic               found;
    logic [ENTRY_W-1:0] index;
  } region_result_t;

  longint             center_x;
  longint             center_y;
  longint             center_z;
  longint             cos_q15;
  longint             sin_q15;
  logic [COUNT_W-1:0] region_count;

  logic [LEN_W-1:0] len_x_tab  [MAX_REGIONS];
  logic [LEN_W-1:0] len_y_tab  [MAX_REGIONS];
  logic [LEN_W-1:0] len_z_tab  [MAX_REGIONS];
  logic [LEN_W-1:0] edge_h_tab [MAX_REGIONS];
  logic [LEN_W-1:0] edge_v_tab [MAX_REGIONS];

  region_result_t expected_results[$];
  region_result_t want;
  int             errors = 0;

  initial begin
    mismatch_count  = 0;
    results_pending = 0;
  end

  function automatic longint twice_mag(input longint a);
    return (a < 0) ? -2 * a : 2 * a;
  endfunction

  function automatic region_result_t lookup_region(input logic signed [COORD_W-1:0] px,
                                                   input logic signed [COORD_W-1:0] py,
                                                   input logic signed [COORD_W-1:0] pz);
    longint         dx;
    longint         dy;
    longint         dz;
    longint         u;
    longint         v;
    int             n;
    region_result_t r;
    dx = longint'(px) - center_x;
    dy = longint'(py) - center_y;
    dz = longint'(pz) - center_z;
    u  = dx * cos_q15 + dy * sin_q15;
    v  = dy * cos_q15 - dx * sin_q15;
    n  = (int'(region_count) > MAX_REGIONS) ? MAX_REGIONS : int'(region_count);
    for (int i = 0; i < n; i++) begin
      if (twice_mag(u) <= longint'(len_x_tab[i]) * 32768 &&
          twice_mag(v) <= longint'(len_y_tab[i]) * 32768 &&
          twice_mag(dz) <= longint'(len_z_tab[i])) begin
        r.edge_h = edge_h_tab[i];
        r.edge_v = edge_v_tab[i];
        r.found  = 1'b1;
        r.index  = ENTRY_W'(i);
        return r;
      end
    end
    r.edge_h = '1;
    r.edge_v = '1;
    r.found  = 1'b0;
    r.index  = '0;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      center_x     = 0;
      center_y     = 0;
      center_z     = 0;
      cos_q15      = longint'(COS_RESET);
      sin_q15      = 0;
      region_count = '0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CENTER_X:     center_x = longint'($signed(cfg_data));
          REG_CENTER_Y:     center_y = longint'($signed(cfg_data));
          REG_CENTER_Z:     center_z = longint'($signed(cfg_data));
          REG_COS_ANGLE:    cos_q15 = longint'($signed(cfg_data[TRIG_W-1:0]));
          REG_SIN_ANGLE:    sin_q15 = longint'($signed(cfg_data[TRIG_W-1:0]));
          REG_REGION_COUNT: region_count = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        if (in_mode == MODE_LOAD) begin
          len_x_tab[in_entry_index]  = in_side_x;
          len_y_tab[in_entry_index]  = in_side_y;
          len_z_tab[in_entry_index]  = in_side_z;
          edge_h_tab[in_entry_index] = in_edge_horizontal_in;
          edge_v_tab[in_entry_index] = in_edge_vertical_in;
        end else begin
          expected_results.push_back(lookup_region(in_point_x, in_point_y, in_point_z));
        end
      end

      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          if (errors < 10) begin
            $display("[%0t] result transfer with no query outstanding: h=%h v=%h found=%0d idx=%0d",
                     $realtime, out_edge_horizontal, out_edge_vertical, out_found,
                     out_region_index);
          end
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_edge_horizontal !== want.edge_h || out_edge_vertical !== want.edge_v ||
              out_found !== want.found || out_region_index !== want.index) begin
            if (errors < 10) begin
              $display("[%0t] lookup mismatch: expected h=%h v=%h found=%0d idx=%0d",
                       $realtime, want.edge_h, want.edge_v, want.found, want.index);
              $display("[%0t]                  actual   h=%h v=%h found=%0d idx=%0d",
                       $realtime, out_edge_horizontal, out_edge_vertical, out_found,
                       out_region_index);
            end
            errors++;
          end
        end
      end
    end
    mismatch_count  <= errors;
    results_pending <= expected_results.size();
  end

endmodule

@@ verif/nested_box_edge_length_lookup_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nested_box_edge_length_lookup_tb
// Drives the region lookup with table loads and point queries under several
// register settings and idling patterns, including a long output stall that
// backs the block up, and reports the verdict from the checker's counts.
// ----------------------------------------------------------------------------
module nested_box_edge_length_lookup_tb;
  import nbel_pkg::*;
  import nbel_tb_pkg::*;

  localparam int CLK_PERIOD      = 20;
  localparam int RESET_CYCLES    = 9;
  localparam int BLOCKS          = 11;
  localparam int ITEMS_PER_BLOCK = 50;
  localparam int PRESSURE_BLOCK  = 5;
  localparam int SETTLE_CYCLES   = 32;
  localparam int HOLD_CYCLES     = 400;
  localparam int CYCLE_LIMIT     = 400000;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    box_mode_t           mode;
    logic [COORD_W-1:0]  px;
    logic [COORD_W-1:0]  py;
    logic [COORD_W-1:0]  pz;
    logic [ENTRY_W-1:0]  idx;
    logic [LEN_W-1:0]    sx;
    logic [LEN_W-1:0]    sy;
    logic [LEN_W-1:0]    sz;
    logic [LEN_W-1:0]    eh;
    logic [LEN_W-1:0]    ev;
  } box_item_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      in_mode = 1'b0;
  logic signed [COORD_W-1:0] in_point_x = '0;
  logic signed [COORD_W-1:0] in_point_y = '0;
  logic signed [COORD_W-1:0] in_point_z = '0;
  logic [ENTRY_W-1:0]        in_entry_index = '0;
  logic [LEN_W-1:0]          in_side_x = '0;
  logic [LEN_W-1:0]          in_side_y = '0;
  logic [LEN_W-1:0]          in_side_z = '0;
  logic [LEN_W-1:0]          in_edge_horizontal_in = '0;
  logic [LEN_W-1:0]          in_edge_vertical_in = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [LEN_W-1:0]          out_edge_horizontal;
  logic [LEN_W-1:0]          out_edge_vertical;
  logic                      out_found;
  logic [ENTRY_W-1:0]        out_region_index;
  int                        mismatch_count;
  int                        results_pending;

  int                        recv_stall = 0;
  int                        hold_requests = 0;
  int                        hold_served = 0;
  int                        hold_left = 0;
  int                        cycle_count = 0;
  logic [COORD_W-1:0]        center_now_x = '0;
  logic [COORD_W-1:0]        center_now_y = '0;
  logic [COORD_W-1:0]        center_now_z = '0;

  nested_box_edge_length_lookup dut (.*);

  nested_box_edge_length_lookup_checker region_check (.*);

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // long output stall, counted here once requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_requests != hold_served) begin
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end
  end

  always @(posedge clk) begin
    out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall);
  end

  function automatic logic [LEN_W-1:0] rand_len(input int bits);
    logic [31:0] r;
    r = $urandom;
    if (bits == 0) return '0;
    return LEN_W'((r & ((32'h1 << bits) - 1)) | (32'h1 << (bits - 1)));
  endfunction

  function automatic logic [COORD_W-1:0] near_center(input logic [COORD_W-1:0] c);
    int          bits;
    logic [31:0] off;
    bits = $urandom_range(31);
    off  = $urandom & ((32'h1 << bits) - 1);
    if ($urandom_range(1) == 1) off = -off;
    return c + off;
  endfunction

  function automatic box_item_t load_item(input logic [ENTRY_W-1:0] idx,
                                          input logic [LEN_W-1:0] sx, sy, sz, eh, ev);
    box_item_t it;
    it.mode = MODE_LOAD;
    it.px   = $urandom;
    it.py   = $urandom;
    it.pz   = $urandom;
    it.idx  = idx;
    it.sx   = sx;
    it.sy   = sy;
    it.sz   = sz;
    it.eh   = eh;
    it.ev   = ev;
    return it;
  endfunction

  function automatic box_item_t query_item(input logic [COORD_W-1:0] px, py, pz);
    box_item_t it;
    it.mode = MODE_QUERY;
    it.px   = px;
    it.py   = py;
    it.pz   = pz;
    it.idx  = ENTRY_W'($urandom);
    it.sx   = LEN_W'($urandom);
    it.sy   = LEN_W'($urandom);
    it.sz   = LEN_W'($urandom);
    it.eh   = LEN_W'($urandom);
    it.ev   = LEN_W'($urandom);
    return it;
  endfunction

  function automatic box_item_t random_item();
    int pick;
    int bits;
    pick = $urandom_range(99);
    bits = $urandom_range(31);
    if (pick < 20) begin
      return load_item(ENTRY_W'($urandom), rand_len(bits), rand_len(bits), rand_len(bits),
                       LEN_W'($urandom), LEN_W'($urandom));
    end else if (pick < 90) begin
      return query_item(near_center(center_now_x), near_center(center_now_y),
                        near_center(center_now_z));
    end
    return query_item($urandom, $urandom, $urandom);
  endfunction

  // call right after a rising edge; returns at the edge of the transfer
  task automatic send_item(input box_item_t item, input int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid              <= 1'b1;
    in_mode               <= item.mode;
    in_point_x            <= item.px;
    in_point_y            <= item.py;
    in_point_z            <= item.pz;
    in_entry_index        <= item.idx;
    in_side_x             <= item.sx;
    in_side_y             <= item.sy;
    in_side_z             <= item.sz;
    in_edge_horizontal_in <= item.eh;
    in_edge_vertical_in   <= item.ev;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic apply_config(input logic [COORD_W-1:0] cx, cy, cz,
                              input logic [TRIG_W-1:0] cosv, sinv,
                              input logic [COUNT_W-1:0] count);
    cfg_write(REG_SPARE_LO, $urandom);
    cfg_write(REG_CENTER_X, cx);
    cfg_write(REG_CENTER_Y, cy);
    cfg_write(REG_CENTER_Z, cz);
    cfg_write(REG_COS_ANGLE, {16'($urandom), cosv});
    cfg_write(REG_SIN_ANGLE, {16'($urandom), sinv});
    cfg_write(REG_REGION_COUNT, {27'($urandom), count});
    cfg_write(REG_SPARE_HI, $urandom);
    cfg_we       <= 1'b0;
    center_now_x = cx;
    center_now_y = cy;
    center_now_z = cz;
  endtask

  function automatic logic [TRIG_W-1:0] rand_trig();
    if ($urandom_range(9) == 0) return TRIG_W'($urandom);
    return TRIG_W'(int'($urandom_range(65534)) - 32767);
  endfunction

  function automatic logic [COORD_W-1:0] rand_center();
    if ($urandom_range(1) == 0) return $urandom;
    return COORD_W'(int'($urandom_range(32'h0020_0000)) - 32'h0010_0000);
  endfunction

  initial begin
    int send_idle;
    int phase;
    send_idle = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no entries in use after reset
    send_item(query_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000), 0);

    // fill the table: empty box first, growing boxes, then the largest
    for (int i = 0; i < 16; i++) begin
      if (i == 0) begin
        send_item(load_item(ENTRY_W'(i), '0, '0, '0, '0, '0), 0);
      end else if (i == 15) begin
        send_item(load_item(ENTRY_W'(i), '1, '1, '1, '1, '1), 0);
      end else begin
        send_item(load_item(ENTRY_W'(i), LEN_W'(1) << (2 * i + 2), LEN_W'(1) << (2 * i + 2),
                            LEN_W'(1) << (2 * i + 2), LEN_W'(i) << 20,
                            LEN_W'(16 - i) << 10), 0);
      end
    end

    settle();
    apply_config('0, '0, '0, COS_RESET, '0, 5'd16);
    send_item(query_item('0, '0, '0), 0);
    send_item(query_item(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000), 0);
    send_item(query_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 0);
    send_item(query_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 0);

    // widest offsets, most negative cosine, count past the table
    settle();
    apply_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'h8000, 16'h7FFF, 5'd31);
    send_item(query_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF), 0);
    send_item(query_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000), 0);

    // no rotation terms, one entry in use
    settle();
    apply_config('0, '0, '0, '0, '0, 5'd1);
    send_item(query_item('0, '0, '0), 0);
    send_item(query_item('0, '0, 32'h0000_0005), 0);

    for (int blk = 0; blk < BLOCKS; blk++) begin
      settle();
      case (blk)
        0: apply_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF, 16'h8001, 5'd16);
        1: apply_config(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h8001, 16'h7FFF, 5'd16);
        2: apply_config(rand_center(), rand_center(), rand_center(), rand_trig(), rand_trig(),
                        5'd0);
        default: apply_config(rand_center(), rand_center(), rand_center(), rand_trig(),
                              rand_trig(),
                              ($urandom_range(9) < 6) ? 5'd16 : COUNT_W'($urandom_range(31)));
      endcase

      phase = blk % 4;
      if (blk == PRESSURE_BLOCK) phase = 0;
      case (phase)
        0: begin send_idle = 0;  recv_stall <= 0;  end
        1: begin send_idle = 74; recv_stall <= 0;  end
        2: begin send_idle = 0;  recv_stall <= 74; end
        default: begin send_idle = 30; recv_stall <= 30; end
      endcase
      if (blk == PRESSURE_BLOCK) hold_requests <= hold_requests + 1;

      for (int n = 0; n < ITEMS_PER_BLOCK; n++) begin
        send_item(random_item(), send_idle);
      end
    end

    settle();
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ nested_box_edge_length_lookup.f @@
design/nbel_pkg.sv
design/nbel_ctrl.sv
design/nbel_datapath.sv
design/nested_box_edge_length_lookup.sv
verif/nbel_tb_pkg.sv
verif/nested_box_edge_length_lookup_checker.sv
verif/nested_box_edge_length_lookup_tb.sv
